@@ rtl/hzd_pkg.sv @@
// Shared types, character codes and pair conversion for the HZ stream decoder.
`timescale 1ns / 1ps

package hzd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PASS_EIGHT_BITS   = 3'd0;
    localparam logic [2:0] REG_NEWLINE_TO_CR     = 3'd1;
    localparam logic [2:0] REG_KEEP_CONTINUATION = 3'd2;
    localparam logic [2:0] REG_MAC_LAYOUT        = 3'd3;
    localparam logic [2:0] REG_BOX_CODE          = 3'd4;
    localparam logic [2:0] REG_SPACE_CODE        = 3'd5;

    localparam logic [15:0] BOX_CODE_RESET   = 16'hA1F5;
    localparam logic [15:0] SPACE_CODE_RESET = 16'hA1A1;

    // Error codes
    localparam logic [2:0] ERR_NONE           = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED_END = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE     = 3'd2;
    localparam logic [2:0] ERR_BAD_PAIR       = 3'd3;
    localparam logic [2:0] ERR_BAD_LEAD       = 3'd4;

    // Characters
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] GB_FIRST  = 8'h21;
    localparam logic [7:0] GB_LEAD_LAST = 8'h77;
    localparam logic [7:0] EXT_LEAD_FIRST = 8'h78;
    localparam logic [7:0] EXT_LEAD_LAST  = 8'h7D;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [7:0] MAC_HI_BASE   = 8'h81;
    localparam logic [7:0] MAC_ODD_BASE  = 8'h40;
    localparam logic [7:0] MAC_EVEN_BASE = 8'h9F;

    typedef struct packed {
        logic        pass_eight_bits;
        logic        newline_to_cr;
        logic        keep_continuation;
        logic        mac_layout;
        logic [15:0] box_code;
        logic [15:0] space_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [2:0]  error_code;
        logic [15:0] error_total;
        logic        last_of_run;
    } out_word_t;

    // One decoded input: one or two result words
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic        two;
        logic        valid0;
        logic [2:0]  error_code;
        logic [15:0] error_total;
    } job_t;

    // Shifted-layout conversion of a valid pair; result is {high, low}
    function automatic logic [15:0] mac_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] hd;
        logic [7:0] ld;
        logic [7:0] h;
        logic [7:0] l;
        hd = hi - GB_FIRST;
        ld = lo - GB_FIRST;
        h  = MAC_HI_BASE + {1'b0, hd[7:1]};
        if (hi[0])
        begin
            l = MAC_ODD_BASE + ld;
            if (l >= CH_DEL)
            begin
                l = l + 8'd1;
            end
        end
        else
        begin
            l = MAC_EVEN_BASE + ld;
        end
        return {h, l};
    endfunction

endpackage

@@ rtl/hz_stream_decoder_core.sv @@
// HZ stream decoder top level: configuration registers, front end, job queue, output sequencer.
`timescale 1ns / 1ps

// Decodes an HZ byte stream into GB bytes. One input word is taken per clock while the
// two-entry job queue has room; each word produces zero, one or two result words, and the
// output sequencer sends one result word per clock while out_ready is high. Throughput is
// one input word per cycle for single-byte results; GB pairs and two-byte repairs are bound
// by the result port, which sends both words. An accepted word passes the job queue and the
// sequencer's current-job register before its first result word. Every result of one input
// carries that input's error code and the running error total (low 16 bits of a saturating
// counter of ERROR_COUNT_BITS bits). The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the decoder is idle; the block does not enforce it.

module hz_stream_decoder_core #(
    parameter int ERROR_COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hzd_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hzd_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    hzd_pkg::cfg_t cfg_reg;
    hzd_pkg::job_t push_job;
    hzd_pkg::job_t pop_job;
    logic          push, pop, q_empty, q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pass_eight_bits   <= 1'b0;
            cfg_reg.newline_to_cr     <= 1'b0;
            cfg_reg.keep_continuation <= 1'b0;
            cfg_reg.mac_layout        <= 1'b0;
            cfg_reg.box_code          <= hzd_pkg::BOX_CODE_RESET;
            cfg_reg.space_code        <= hzd_pkg::SPACE_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hzd_pkg::REG_PASS_EIGHT_BITS:   cfg_reg.pass_eight_bits   <= cfg_data[0];
                hzd_pkg::REG_NEWLINE_TO_CR:     cfg_reg.newline_to_cr     <= cfg_data[0];
                hzd_pkg::REG_KEEP_CONTINUATION: cfg_reg.keep_continuation <= cfg_data[0];
                hzd_pkg::REG_MAC_LAYOUT:        cfg_reg.mac_layout        <= cfg_data[0];
                hzd_pkg::REG_BOX_CODE:          cfg_reg.box_code          <= cfg_data;
                hzd_pkg::REG_SPACE_CODE:        cfg_reg.space_code        <= cfg_data;
                default:                        ;
            endcase
        end
    end

    hzd_front #(
        .ERROR_COUNT_BITS(ERROR_COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    hzd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    hzd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/hzd_front.sv @@
// Front end: accepts HZ words, tracks escape/GB state and builds result jobs.
`timescale 1ns / 1ps

module hzd_front #(
    parameter int ERROR_COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hzd_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  hzd_pkg::in_word_t in_data,
    input  logic              q_full,
    output logic              push,
    output hzd_pkg::job_t     job
);

    logic                        gb_mode_reg, gb_mode_next;
    logic                        esc_reg, esc_next;
    logic                        lead_reg, lead_next;
    logic [7:0]                  lead_byte_reg, lead_byte_next;
    logic [ERROR_COUNT_BITS-1:0] err_cnt_reg, err_cnt_next;

    logic        accept;
    logic [7:0]  c;
    logic [7:0]  hi;
    logic        trail_ok;
    logic        count_err;
    logic [1:0]  n;
    logic [7:0]  b0, b1;
    logic [2:0]  err;
    logic [15:0] pair;
    logic [31:0] cnt_ext;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign c        = cfg.pass_eight_bits ? in_data.in_byte : {1'b0, in_data.in_byte[6:0]};
    assign hi       = lead_byte_reg;
    assign trail_ok = (c >= hzd_pkg::GB_FIRST) && (c <= hzd_pkg::CH_TILDE);
    assign pair     = cfg.mac_layout ? hzd_pkg::mac_pair(hi, c)
                                     : {hi | hzd_pkg::HIGH_BIT, c | hzd_pkg::HIGH_BIT};

    always_comb
    begin
        gb_mode_next   = gb_mode_reg;
        esc_next       = esc_reg;
        lead_next      = lead_reg;
        lead_byte_next = lead_byte_reg;
        count_err      = 1'b0;
        n              = 2'd0;
        b0             = 8'h00;
        b1             = 8'h00;
        err            = hzd_pkg::ERR_NONE;

        if (in_data.end_of_input)
        begin
            if (esc_reg || lead_reg)
            begin
                err       = hzd_pkg::ERR_UNEXPECTED_END;
                count_err = 1'b1;
            end
            esc_next       = 1'b0;
            lead_next      = 1'b0;
            lead_byte_next = 8'h00;
            gb_mode_next   = 1'b0;
            n              = 2'd1;
        end
        else if (!gb_mode_reg)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                priority if (c == hzd_pkg::CH_TILDE)
                begin
                    n  = 2'd1;
                    b0 = hzd_pkg::CH_TILDE;
                end
                else if (c == hzd_pkg::CH_LBRACE)
                begin
                    gb_mode_next = 1'b1;
                end
                else if (c == hzd_pkg::CH_LF)
                begin
                    if (cfg.keep_continuation)
                    begin
                        n  = 2'd1;
                        b0 = hzd_pkg::CH_LF;
                    end
                end
                else
                begin
                    err       = hzd_pkg::ERR_BAD_ESCAPE;
                    count_err = 1'b1;
                    n         = 2'd2;
                    b0        = hzd_pkg::CH_TILDE;
                    b1        = c;
                end
            end
            else if (c == hzd_pkg::CH_TILDE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                n  = 2'd1;
                b0 = (cfg.newline_to_cr && c == hzd_pkg::CH_LF) ? hzd_pkg::CH_CR : c;
            end
        end
        else if (!lead_reg)
        begin
            if (c >= hzd_pkg::CH_SPACE && c <= hzd_pkg::CH_TILDE)
            begin
                lead_next      = 1'b1;
                lead_byte_next = c;
            end
            else
            begin
                err          = hzd_pkg::ERR_BAD_LEAD;
                count_err    = 1'b1;
                gb_mode_next = 1'b0;
                n            = 2'd1;
                b0           = c;
            end
        end
        else
        begin
            lead_next      = 1'b0;
            lead_byte_next = 8'h00;
            priority if (hi >= hzd_pkg::GB_FIRST && hi <= hzd_pkg::GB_LEAD_LAST && trail_ok)
            begin
                n  = 2'd2;
                b0 = pair[15:8];
                b1 = pair[7:0];
            end
            else if (hi == hzd_pkg::CH_TILDE && c == hzd_pkg::CH_RBRACE)
            begin
                gb_mode_next = 1'b0;
            end
            else
            begin
                err       = hzd_pkg::ERR_BAD_PAIR;
                count_err = 1'b1;
                priority if (hi >= hzd_pkg::EXT_LEAD_FIRST && hi <= hzd_pkg::EXT_LEAD_LAST
                             && trail_ok)
                begin
                    n  = 2'd2;
                    b0 = cfg.box_code[15:8];
                    b1 = cfg.box_code[7:0];
                end
                else if (hi == hzd_pkg::CH_TILDE)
                begin
                    gb_mode_next = 1'b0;
                    n            = 2'd2;
                    b0           = hi;
                    b1           = c;
                end
                else if (hi == hzd_pkg::CH_SPACE)
                begin
                    n  = 2'd1;
                    b0 = c;
                end
                else if (c == hzd_pkg::CH_SPACE)
                begin
                    n  = 2'd2;
                    b0 = cfg.space_code[15:8];
                    b1 = cfg.space_code[7:0];
                end
                else
                begin
                    gb_mode_next = 1'b0;
                    n            = 2'd2;
                    b0           = hi;
                    b1           = c;
                end
            end
        end
    end

    // saturating error count
    assign err_cnt_next = (count_err && (err_cnt_reg != '1)) ? err_cnt_reg + 1'b1 : err_cnt_reg;
    assign cnt_ext      = 32'(err_cnt_next);

    assign push             = accept && (n != 2'd0);
    assign job.byte0        = b0;
    assign job.byte1        = b1;
    assign job.two          = (n == 2'd2);
    assign job.valid0       = !in_data.end_of_input;
    assign job.error_code   = err;
    assign job.error_total  = cnt_ext[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gb_mode_reg   <= 1'b0;
            esc_reg       <= 1'b0;
            lead_reg      <= 1'b0;
            lead_byte_reg <= 8'h00;
            err_cnt_reg   <= '0;
        end
        else if (accept)
        begin
            gb_mode_reg   <= gb_mode_next;
            esc_reg       <= esc_next;
            lead_reg      <= lead_next;
            lead_byte_reg <= lead_byte_next;
            err_cnt_reg   <= err_cnt_next;
        end
    end

endmodule

@@ rtl/hzd_queue.sv @@
// Two-entry job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module hzd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hzd_pkg::job_t push_job,
    input  logic          pop,
    output hzd_pkg::job_t pop_job,
    output logic          empty,
    output logic          full
);

    hzd_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/hzd_back.sv @@
// Output sequencer: turns each job into one or two result words.
`timescale 1ns / 1ps

module hzd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  hzd_pkg::job_t      q_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output hzd_pkg::out_word_t out_data
);

    hzd_pkg::job_t cur_reg;
    logic          busy_reg, busy_next;
    logic          phase_reg, phase_next;
    logic          last;
    logic          done;

    assign last      = !cur_reg.two || phase_reg;
    assign done      = busy_reg && out_ready && last;
    assign pop       = (!busy_reg || done) && !q_empty;
    assign out_valid = busy_reg;

    assign out_data.out_byte    = phase_reg ? cur_reg.byte1 : cur_reg.byte0;
    assign out_data.byte_valid  = phase_reg ? 1'b1 : cur_reg.valid0;
    assign out_data.error_code  = cur_reg.error_code;
    assign out_data.error_total = cur_reg.error_total;
    assign out_data.last_of_run = last;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
        end
        else if (done)
        begin
            busy_next  = 1'b0;
            phase_next = 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ rtl/hzd_checker.sv @@
// Port-level checks on the decoder result channel, bound to the top level.
`timescale 1ns / 1ps

module hzd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input hzd_pkg::out_word_t out_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // status-only word is always the single word of its input
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.last_of_run && out_data.out_byte == 8'h00)
        else $error("status word malformed");

    // second word of a pair follows at once with the same status
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=>
            out_valid && out_data.byte_valid && out_data.last_of_run
            && $stable(out_data.error_code) && $stable(out_data.error_total))
        else $error("second word of a pair missing or inconsistent");

    // first word of a pair carries data
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |-> out_data.byte_valid)
        else $error("first word of a pair has no data");

endmodule

bind hz_stream_decoder_core hzd_checker u_hzd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
